// File: rtl/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: shared package
// Types, codes and constants shared by the front, the back and the top level.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam logic [1:0]  OP_WRITE        = 2'd1;
  localparam logic [1:0]  OP_READ         = 2'd2;
  localparam logic [7:0]  CTRL_WRITE      = 8'hA0;
  localparam logic [7:0]  CTRL_READ       = 8'hA1;
  localparam logic [15:0] PHASE_LEN_RESET = 16'd50;
  localparam logic        SEL_PHASE_LEN   = 1'b0;
  localparam int          QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_WRITE,
    REQ_READ
  } req_t;

  typedef struct packed {
    req_t        req;
    logic [10:0] address;
    logic [7:0]  write_data;
    logic        sda_in;
  } req_word_t;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_START,
    SEG_TX,
    SEG_RX,
    SEG_NACK,
    SEG_RESTART,
    SEG_STOP
  } seg_t;

endpackage

// File: rtl/i2cee_if.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface i2cee_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [10:0] address;
  logic [7:0]  write_data;
  logic        sda_in;

  modport source (output valid, op, address, write_data, sda_in, input ready);
  modport sink (input valid, op, address, write_data, sda_in, output ready);
endinterface

interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nack_seen;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data, nack_seen,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_data, nack_seen,
                output ready);
endinterface

// File: rtl/i2c_eeprom_byte_access_master_core.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: top level
// Bit-level I2C master for byte writes and reads of a 2 KiB serial EEPROM.
// ----------------------------------------------------------------------------
// A word's result passes through the input queue and then the output register, and
// it is held in the output register until taken.
// Throughput: one word per cycle unless the result channel stalls; the sequencer steps once per word.
// Reset: synchronous, active low; the sequencer is idle, both pins are
// released and the phase length returns to 50 ticks.
module i2c_eeprom_byte_access_master_core #(
  parameter int QUEUE_DEPTH = i2cee_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  i2cee_in_if.sink    in_ch,
  i2cee_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]          phase_len_r;
  i2cee_pkg::req_word_t head_word;
  logic                 head_valid;
  logic                 head_pop;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == i2cee_pkg::SEL_PHASE_LEN) ? {16'd0, phase_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_len_r <= i2cee_pkg::PHASE_LEN_RESET;
    end else if (cfg_write && paddr[2] == i2cee_pkg::SEL_PHASE_LEN) begin
      phase_len_r <= pwdata[15:0];
    end
  end

  i2cee_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head_word  (head_word),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  i2cee_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .phase_len  (phase_len_r),
    .head_word  (head_word),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_ch     (out_ch)
  );

  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> out_ch.busy_res)
    else $error("done reported outside a transaction");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.busy_res |-> out_ch.scl_out && out_ch.sda_out)
    else $error("bus not released while idle");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write && paddr[2] == i2cee_pkg::SEL_PHASE_LEN
    |=> paddr[2] != i2cee_pkg::SEL_PHASE_LEN || prdata[15:0] == $past(pwdata[15:0]))
    else $error("phase length readback mismatch");

endmodule

// File: rtl/i2cee_front.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: front end
// Accepts input words, classifies the op code and queues the words.
// ----------------------------------------------------------------------------
module i2cee_front #(
  parameter int DEPTH = i2cee_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  i2cee_in_if.sink             in_ch,
  output i2cee_pkg::req_word_t head_word,
  output logic                 head_valid,
  input  logic                 head_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  i2cee_pkg::req_word_t mem_r [DEPTH];
  i2cee_pkg::req_word_t push_word;
  logic [PW-1:0]        wr_ptr_r;
  logic [PW-1:0]        rd_ptr_r;
  logic [CW-1:0]        count_r;
  logic                 push;

  always_comb begin
    unique case (in_ch.op)
      i2cee_pkg::OP_WRITE: push_word.req = i2cee_pkg::REQ_WRITE;
      i2cee_pkg::OP_READ:  push_word.req = i2cee_pkg::REQ_READ;
      default:             push_word.req = i2cee_pkg::REQ_TICK;
    endcase
    push_word.address    = in_ch.address;
    push_word.write_data = in_ch.write_data;
    push_word.sda_in     = in_ch.sda_in;
  end

  assign in_ch.ready = (count_r != CW'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (count_r != '0);
  assign head_word   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (head_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !head_pop) begin
        count_r <= count_r + CW'(1);
      end else if (!push && head_pop) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/i2cee_back.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: back end
// Bus sequencer that runs one tick per queued word and registers the result.
// ----------------------------------------------------------------------------
module i2cee_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          phase_len,
  input  i2cee_pkg::req_word_t head_word,
  input  logic                 head_valid,
  output logic                 head_pop,
  i2cee_out_if.source          out_ch
);

  i2cee_pkg::seg_t seg_r, seg_nxt;
  logic [1:0]      sub_r, sub_nxt;
  logic [15:0]     tick_r, tick_nxt;
  logic [3:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [1:0]      slot_r, slot_nxt;
  logic            is_read_r, is_read_nxt;
  logic [10:0]     addr_r, addr_nxt;
  logic [7:0]      data_r, data_nxt;
  logic [7:0]      rx_r, rx_nxt;
  logic            nack_r, nack_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic            out_valid_r;
  logic [15:0]     plen;
  logic [15:0]     plen_m1;
  logic [7:0]      blk_bits;
  logic            enter;

  assign head_pop = head_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r     <= i2cee_pkg::SEG_IDLE;
      sub_r     <= '0;
      tick_r    <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      slot_r    <= '0;
      is_read_r <= 1'b0;
      addr_r    <= '0;
      data_r    <= '0;
      rx_r      <= '0;
      nack_r    <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
    end else if (head_pop) begin
      seg_r     <= seg_nxt;
      sub_r     <= sub_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      slot_r    <= slot_nxt;
      is_read_r <= is_read_nxt;
      addr_r    <= addr_nxt;
      data_r    <= data_nxt;
      rx_r      <= rx_nxt;
      nack_r    <= nack_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (head_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    plen        = (phase_len == '0) ? 16'd1 : phase_len;
    plen_m1     = plen - 16'd1;
    blk_bits    = {4'b0000, addr_r[10:8], 1'b0};
    seg_nxt     = seg_r;
    sub_nxt     = sub_r;
    tick_nxt    = tick_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    slot_nxt    = slot_r;
    is_read_nxt = is_read_r;
    addr_nxt    = addr_r;
    data_nxt    = data_r;
    rx_nxt      = rx_r;
    nack_nxt    = nack_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    busy_nxt    = 1'b0;
    done_nxt    = 1'b0;
    enter       = 1'b0;

    if (seg_r == i2cee_pkg::SEG_IDLE) begin
      if (head_word.req == i2cee_pkg::REQ_WRITE || head_word.req == i2cee_pkg::REQ_READ) begin
        addr_nxt    = head_word.address;
        data_nxt    = head_word.write_data;
        is_read_nxt = (head_word.req == i2cee_pkg::REQ_READ);
        nack_nxt    = 1'b0;
        slot_nxt    = '0;
        bit_nxt     = '0;
        tick_nxt    = '0;
        seg_nxt     = i2cee_pkg::SEG_START;
        sub_nxt     = 2'd0;
        enter       = 1'b1;
      end
    end else if (tick_r >= plen) begin
      tick_nxt = '0;
      enter    = 1'b1;
      unique case (seg_r)
        i2cee_pkg::SEG_START: begin
          if (sub_r == 2'd0) begin
            sub_nxt = 2'd1;
          end else begin
            slot_nxt  = 2'd0;
            shift_nxt = i2cee_pkg::CTRL_WRITE | blk_bits;
            bit_nxt   = '0;
            seg_nxt   = i2cee_pkg::SEG_TX;
            sub_nxt   = 2'd0;
          end
        end
        i2cee_pkg::SEG_TX: begin
          if (bit_r < 4'd8) begin
            if (sub_r < 2'd2) begin
              sub_nxt = sub_r + 2'd1;
            end else begin
              bit_nxt = bit_r + 4'd1;
              sub_nxt = 2'd0;
            end
          end else if (sub_r == 2'd0) begin
            sub_nxt = 2'd1;
          end else if (slot_r == 2'd0) begin
            slot_nxt  = 2'd1;
            shift_nxt = addr_r[7:0];
            bit_nxt   = '0;
            sub_nxt   = 2'd0;
          end else if (slot_r == 2'd1) begin
            if (is_read_r) begin
              seg_nxt = i2cee_pkg::SEG_RESTART;
              sub_nxt = 2'd0;
            end else begin
              slot_nxt  = 2'd2;
              shift_nxt = data_r;
              bit_nxt   = '0;
              sub_nxt   = 2'd0;
            end
          end else if (is_read_r) begin
            shift_nxt = '0;
            bit_nxt   = '0;
            seg_nxt   = i2cee_pkg::SEG_RX;
            sub_nxt   = 2'd0;
          end else begin
            seg_nxt = i2cee_pkg::SEG_STOP;
            sub_nxt = 2'd0;
          end
        end
        i2cee_pkg::SEG_RX: begin
          if (sub_r < 2'd2) begin
            sub_nxt = sub_r + 2'd1;
          end else if (bit_r < 4'd7) begin
            bit_nxt = bit_r + 4'd1;
            sub_nxt = 2'd0;
          end else begin
            rx_nxt  = shift_r;
            seg_nxt = i2cee_pkg::SEG_NACK;
            sub_nxt = 2'd0;
          end
        end
        i2cee_pkg::SEG_NACK: begin
          if (sub_r < 2'd2) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            seg_nxt = i2cee_pkg::SEG_STOP;
            sub_nxt = 2'd0;
          end
        end
        i2cee_pkg::SEG_RESTART: begin
          if (sub_r < 2'd3) begin
            sub_nxt = sub_r + 2'd1;
          end else begin
            slot_nxt  = 2'd2;
            shift_nxt = i2cee_pkg::CTRL_READ | blk_bits;
            bit_nxt   = '0;
            seg_nxt   = i2cee_pkg::SEG_TX;
            sub_nxt   = 2'd0;
          end
        end
        i2cee_pkg::SEG_STOP: begin
          if (sub_r < 2'd3) begin
            sub_nxt = sub_r + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end

    if (enter) begin
      unique case (seg_nxt)
        i2cee_pkg::SEG_START: begin
          if (sub_nxt == 2'd0) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b0;
          end
        end
        i2cee_pkg::SEG_TX: begin
          if (bit_nxt < 4'd8) begin
            if (sub_nxt == 2'd0) begin
              scl_nxt = 1'b0;
            end else if (sub_nxt == 2'd1) begin
              sda_nxt = shift_nxt[~bit_nxt[2:0]];
            end else begin
              scl_nxt = 1'b1;
            end
          end else if (sub_nxt == 2'd0) begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b1;
          end
        end
        i2cee_pkg::SEG_RX: begin
          if (sub_nxt == 2'd0) begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b1;
          end else if (sub_nxt == 2'd1) begin
            scl_nxt = 1'b1;
          end
        end
        i2cee_pkg::SEG_NACK: begin
          if (sub_nxt == 2'd0) begin
            scl_nxt = 1'b0;
          end else if (sub_nxt == 2'd1) begin
            sda_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b1;
          end
        end
        i2cee_pkg::SEG_RESTART, i2cee_pkg::SEG_STOP: begin
          if (sub_nxt == 2'd0) begin
            scl_nxt = 1'b0;
          end else if (sub_nxt == 2'd1) begin
            sda_nxt = (seg_nxt == i2cee_pkg::SEG_RESTART);
          end else if (sub_nxt == 2'd2) begin
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = (seg_nxt == i2cee_pkg::SEG_STOP);
          end
        end
        default: begin
        end
      endcase
    end

    if (seg_nxt != i2cee_pkg::SEG_IDLE) begin
      busy_nxt = 1'b1;
      if (tick_nxt >= plen_m1) begin
        if (seg_nxt == i2cee_pkg::SEG_TX && bit_nxt == 4'd8 && sub_nxt == 2'd1) begin
          nack_nxt = nack_nxt | head_word.sda_in;
        end else if (seg_nxt == i2cee_pkg::SEG_RX && sub_nxt == 2'd1) begin
          shift_nxt = {shift_nxt[6:0], head_word.sda_in};
        end
        if (seg_nxt == i2cee_pkg::SEG_STOP && sub_nxt == 2'd3) begin
          done_nxt = 1'b1;
          seg_nxt  = i2cee_pkg::SEG_IDLE;
          sub_nxt  = 2'd0;
          tick_nxt = '0;
        end else begin
          tick_nxt = tick_nxt + 16'd1;
        end
      end else begin
        tick_nxt = tick_nxt + 16'd1;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_out   = scl_r;
  assign out_ch.sda_out   = sda_r;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.read_data = rx_r;
  assign out_ch.nack_seen = nack_r;

endmodule

// File: tb/sv/i2c_eeprom_byte_access_master_core_test.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte access master: self-checking testbench
// Drives tick words, with byte write and byte read requests among them, into
// the core and checks every result word against a word-by-word model of the
// pin sequencer. The phase length is changed between runs of words, also in
// the middle of a transfer. Both channels idle at random.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master_core_test;
  import i2cee_pkg::*;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [2:0] PHASE_LEN_ADDR = 3'd0;
  localparam int CYCLE_LIMIT = 300000;
  localparam int WORDS_PER_RUN = 142;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       nack;
  } line_state_t;

  class i2c_master_scoreboard;
    logic [15:0]  phase_len;
    int unsigned  ticks;
    seg_t         seg;
    logic [1:0]   sub;
    int unsigned  bit_idx;
    int unsigned  slot;
    logic [7:0]   shifter;
    logic         rd;
    logic [10:0]  addr_q;
    logic [7:0]   data_q;
    logic [7:0]   rx;
    logic         nack;
    logic         scl;
    logic         sda;
    line_state_t  expected_q[$];
    int           errors;
    int           words;
    int           results;
    int           writes_done;
    int           reads_done;
    int           nacked;

    function new();
      phase_len = PHASE_LEN_RESET;
      ticks = 0;
      seg = SEG_IDLE;
      sub = 2'd0;
      bit_idx = 0;
      slot = 0;
      shifter = 8'h00;
      rd = 1'b0;
      addr_q = 11'h000;
      data_q = 8'h00;
      rx = 8'h00;
      nack = 1'b0;
      scl = 1'b1;
      sda = 1'b1;
      errors = 0;
      words = 0;
      results = 0;
      writes_done = 0;
      reads_done = 0;
      nacked = 0;
    endfunction

    function void set_phase_len(logic [15:0] value);
      phase_len = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit idle();
      return seg == SEG_IDLE;
    endfunction

    function void load_byte(logic [7:0] value);
      shifter = value;
      bit_idx = 0;
      seg = SEG_TX;
      sub = 2'd0;
    endfunction

    function void drive_pins();
      case (seg)
        SEG_START: begin
          if (sub == 2'd0) begin
            scl = 1'b1;
            sda = 1'b1;
          end else begin
            sda = 1'b0;
          end
        end
        SEG_TX: begin
          if (bit_idx < 8) begin
            if (sub == 2'd0) scl = 1'b0;
            else if (sub == 2'd1) sda = shifter[7 - bit_idx];
            else scl = 1'b1;
          end else if (sub == 2'd0) begin
            scl = 1'b0;
            sda = 1'b1;
          end else begin
            scl = 1'b1;
          end
        end
        SEG_RX: begin
          if (sub == 2'd0) begin
            scl = 1'b0;
            sda = 1'b1;
          end else if (sub == 2'd1) begin
            scl = 1'b1;
          end
        end
        SEG_NACK: begin
          if (sub == 2'd0) scl = 1'b0;
          else if (sub == 2'd1) sda = 1'b1;
          else scl = 1'b1;
        end
        SEG_RESTART: begin
          if (sub == 2'd0) scl = 1'b0;
          else if (sub == 2'd1) sda = 1'b1;
          else if (sub == 2'd2) scl = 1'b1;
          else sda = 1'b0;
        end
        SEG_STOP: begin
          if (sub == 2'd0) scl = 1'b0;
          else if (sub == 2'd1) sda = 1'b0;
          else if (sub == 2'd2) scl = 1'b1;
          else sda = 1'b1;
        end
        default: begin
        end
      endcase
    endfunction

    // Works out the result word caused by one accepted tick word.
    function void note_word(logic [1:0] op, logic [10:0] address, logic [7:0] wdata,
                            logic sda_in);
      int unsigned plen;
      logic        busy;
      logic        done;
      logic [7:0]  ctrl_block;
      line_state_t want;
      plen = (phase_len == 16'd0) ? 1 : phase_len;
      busy = 1'b0;
      done = 1'b0;
      words++;
      if (seg == SEG_IDLE) begin
        if (op == OP_WRITE || op == OP_READ) begin
          addr_q = address;
          data_q = wdata;
          rd = (op == OP_READ);
          nack = 1'b0;
          slot = 0;
          bit_idx = 0;
          ticks = 0;
          seg = SEG_START;
          sub = 2'd0;
          drive_pins();
        end
      end else if (ticks >= plen) begin
        ctrl_block = {4'b0000, addr_q[10:8], 1'b0};
        case (seg)
          SEG_START: begin
            if (sub == 2'd0) begin
              sub = 2'd1;
            end else begin
              slot = 0;
              load_byte(CTRL_WRITE | ctrl_block);
            end
          end
          SEG_TX: begin
            if (bit_idx < 8) begin
              if (sub < 2'd2) begin
                sub++;
              end else begin
                bit_idx++;
                sub = 2'd0;
              end
            end else if (sub == 2'd0) begin
              sub = 2'd1;
            end else if (slot == 0) begin
              slot = 1;
              load_byte(addr_q[7:0]);
            end else if (slot == 1) begin
              if (rd) begin
                seg = SEG_RESTART;
                sub = 2'd0;
              end else begin
                slot = 2;
                load_byte(data_q);
              end
            end else if (rd) begin
              shifter = 8'h00;
              bit_idx = 0;
              seg = SEG_RX;
              sub = 2'd0;
            end else begin
              seg = SEG_STOP;
              sub = 2'd0;
            end
          end
          SEG_RX: begin
            if (sub < 2'd2) begin
              sub++;
            end else if (bit_idx < 7) begin
              bit_idx++;
              sub = 2'd0;
            end else begin
              rx = shifter;
              seg = SEG_NACK;
              sub = 2'd0;
            end
          end
          SEG_NACK: begin
            if (sub < 2'd2) begin
              sub++;
            end else begin
              seg = SEG_STOP;
              sub = 2'd0;
            end
          end
          SEG_RESTART: begin
            if (sub < 2'd3) begin
              sub++;
            end else begin
              slot = 2;
              load_byte(CTRL_READ | ctrl_block);
            end
          end
          SEG_STOP: begin
            if (sub < 2'd3) sub++;
          end
          default: begin
          end
        endcase
        drive_pins();
        ticks = 0;
      end
      if (seg != SEG_IDLE) begin
        busy = 1'b1;
        if (ticks + 1 >= plen) begin
          if (seg == SEG_TX && bit_idx == 8 && sub == 2'd1) nack = nack | sda_in;
          else if (seg == SEG_RX && sub == 2'd1) shifter = {shifter[6:0], sda_in};
          if (seg == SEG_STOP && sub == 2'd3) begin
            done = 1'b1;
            seg = SEG_IDLE;
            ticks = 0;
            if (rd) reads_done++;
            else writes_done++;
            if (nack) nacked++;
          end else begin
            ticks = (ticks + 1) & 32'h1FFFF;
          end
        end else begin
          ticks++;
        end
      end
      want.scl = scl;
      want.sda = sda;
      want.busy = busy;
      want.done = done;
      want.rdata = rx;
      want.nack = nack;
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("mismatch: %s", msg);
    endtask

    task check_result(line_state_t got);
      line_state_t want;
      results++;
      if (expected_q.size() == 0) begin
        report($sformatf("result word %0d arrived with nothing expected", results));
      end else begin
        want = expected_q.pop_front();
        if (got.scl !== want.scl)
          report($sformatf("word %0d scl_out %b, expected %b", results, got.scl, want.scl));
        if (got.sda !== want.sda)
          report($sformatf("word %0d sda_out %b, expected %b", results, got.sda, want.sda));
        if (got.busy !== want.busy)
          report($sformatf("word %0d busy_res %b, expected %b", results, got.busy, want.busy));
        if (got.done !== want.done)
          report($sformatf("word %0d done_res %b, expected %b", results, got.done, want.done));
        if (got.rdata !== want.rdata)
          report($sformatf("word %0d read_data %h, expected %h", results, got.rdata,
                           want.rdata));
        if (got.nack !== want.nack)
          report($sformatf("word %0d nack_seen %b, expected %b", results, got.nack, want.nack));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          steady;
  int          cycles = 0;

  i2c_master_scoreboard sb;

  i2cee_in_if  in_ch ();
  i2cee_out_if out_ch ();

  i2c_eeprom_byte_access_master_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task send_word(logic [1:0] op, logic [10:0] address, logic [7:0] wdata, logic sda_in);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.address <= address;
    in_ch.write_data <= wdata;
    in_ch.sda_in <= sda_in;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(op, address, wdata, sda_in);
  endtask

  task send_tick();
    send_word(OP_TICK, 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)),
              $urandom_range(0, 2) == 0);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task set_phase_len(logic [15:0] value);
    logic [15:0] readback;
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PHASE_LEN_ADDR;
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_phase_len(value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata[15:0];
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== value)
      sb.report($sformatf("phase_len read back as %0d, written %0d", readback, value));
  endtask

  initial begin
    line_state_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!steady) begin
        int stall;
        stall = $urandom_range(0, 5);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.scl = out_ch.scl_out;
      got.sda = out_ch.sda_out;
      got.busy = out_ch.busy_res;
      got.done = out_ch.done_res;
      got.rdata = out_ch.read_data;
      got.nack = out_ch.nack_seen;
      sb.check_result(got);
    end
  end

  initial begin
    logic [15:0] run_len[6];
    logic [1:0]  op;
    logic [15:0] readback;
    run_len = '{16'd1, 16'd2, 16'd1, 16'd0, 16'd3, 16'd4};
    sb = new();
    steady = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_TICK;
    in_ch.address <= 11'h000;
    in_ch.write_data <= 8'h00;
    in_ch.sda_in <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PHASE_LEN_ADDR;
    pwdata <= 32'h0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata[15:0];
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== PHASE_LEN_RESET)
      sb.report($sformatf("phase_len after reset read as %0d", readback));

    // The spare op code is a plain tick; requests while busy are dropped.
    send_word(OP_SPARE, 11'h7FF, 8'hFF, 1'b1);
    send_word(OP_TICK, 11'h000, 8'h00, 1'b0);
    send_word(OP_WRITE, 11'h7FF, 8'hFF, 1'b0);
    repeat (4) send_tick();
    send_word(OP_READ, 11'h000, 8'h00, 1'b1);
    send_word(OP_WRITE, 11'h2AA, 8'h55, 1'b1);
    // Stretch the phase mid transfer, then shrink it below the tick count.
    set_phase_len(16'hFFFF);
    repeat (3) send_tick();
    set_phase_len(16'd1);
    repeat (4) send_tick();
    set_phase_len(16'd0);
    repeat (6) send_tick();

    for (int r = 0; r < 6; r++) begin
      set_phase_len(run_len[r]);
      steady = (r == 2);
      for (int i = 0; i < WORDS_PER_RUN; i++) begin
        op = OP_TICK;
        if (sb.idle()) begin
          case ($urandom_range(0, 7))
            0: op = OP_TICK;
            1: op = OP_SPARE;
            2, 3, 4: op = OP_WRITE;
            default: op = OP_READ;
          endcase
        end else if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 2))
            0: op = OP_WRITE;
            1: op = OP_READ;
            default: op = OP_SPARE;
          endcase
        end
        send_word(op, 11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 2) == 0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("Checked %0d words at phase lengths of 0 to 4 and 65535.", sb.words);
    $display("Finished %0d byte writes and %0d byte reads; %0d saw a nack.",
             sb.writes_done, sb.reads_done, sb.nacked);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
